FILE: rtl/core/tpt_pkg.sv
package tpt_pkg;

  localparam int unsigned ENERGY_W  = 32;
  localparam int unsigned WAIT_W    = 32;
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned REC_W     = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_INHERENT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS = 4'd3;

  localparam logic [REC_W-1:0] MAX_RECORDS_RST = 16'hFFFF;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] prev_energy;
    logic signed [ENERGY_W-1:0] prev_inherent;
    logic signed [ENERGY_W-1:0] curr_energy;
    logic signed [ENERGY_W-1:0] curr_inherent;
    logic        [WAIT_W-1:0]   wait_time;
  } tpt_item_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] ridge_energy;
    logic        [STEP_W-1:0]   steps_above;
    logic        [TIME_W-1:0]   time_above;
    logic                       same_basin;
  } tpt_res_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] threshold;
    logic                       threshold_enable;
    logic                       use_inherent_energy;
    logic        [REC_W-1:0]    max_records;
  } tpt_cfg_t;

endpackage

FILE: rtl/core/tpt_if.sv
interface tpt_in_if;
  import tpt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ENERGY_W-1:0] prev_energy;
  logic signed [ENERGY_W-1:0] prev_inherent;
  logic signed [ENERGY_W-1:0] curr_energy;
  logic signed [ENERGY_W-1:0] curr_inherent;
  logic        [WAIT_W-1:0]   wait_time;

  modport source (output valid, prev_energy, prev_inherent, curr_energy, curr_inherent,
                  wait_time, input ready);
  modport sink   (input valid, prev_energy, prev_inherent, curr_energy, curr_inherent,
                  wait_time, output ready);
endinterface

interface tpt_out_if;
  import tpt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ENERGY_W-1:0] ridge_energy;
  logic        [STEP_W-1:0]   steps_above;
  logic        [TIME_W-1:0]   time_above;
  logic                       same_basin;

  modport source (output valid, ridge_energy, steps_above, time_above, same_basin,
                  input ready);
  modport sink   (input valid, ridge_energy, steps_above, time_above, same_basin,
                  output ready);
endinterface

interface tpt_cfg_if;
  import tpt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tpt_cfg_regs.sv
module tpt_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [tpt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [tpt_pkg::CFG_DAT_W-1:0] wr_data,
  output tpt_pkg::tpt_cfg_t             cfg
);
  import tpt_pkg::*;

  tpt_cfg_t cfg_r, cfg_nxt;

  // Decode one write beat; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_THRESHOLD:    cfg_nxt.threshold           = signed'(wr_data[ENERGY_W-1:0]);
        CFG_ENABLE:       cfg_nxt.threshold_enable    = wr_data[0];
        CFG_USE_INHERENT: cfg_nxt.use_inherent_energy = wr_data[0];
        CFG_MAX_RECORDS:  cfg_nxt.max_records         = wr_data[REC_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold           <= '0;
      cfg_r.threshold_enable    <= 1'b1;
      cfg_r.use_inherent_energy <= 1'b0;
      cfg_r.max_records         <= MAX_RECORDS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/tpt_in_stage.sv
module tpt_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpt_pkg::tpt_item_t in_item,
  input  logic               take,
  output logic               s1_valid,
  output tpt_pkg::tpt_item_t s1_item
);
  import tpt_pkg::*;

  logic      valid_r, valid_nxt;
  tpt_item_t item_r;

  // Refill whenever the held beat moves on or the stage is empty
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: rtl/core/tpt_track.sv
module tpt_track (
  input  logic               clk,
  input  logic               rst_n,
  input  tpt_pkg::tpt_cfg_t  cfg,
  input  logic               fire,
  input  tpt_pkg::tpt_item_t item,
  output logic               res_valid,
  output tpt_pkg::tpt_res_t  res
);
  import tpt_pkg::*;

  logic signed [ENERGY_W-1:0] entry_r, entry_nxt;
  logic signed [ENERGY_W-1:0] peak_r, peak_nxt;
  logic        [STEP_W-1:0]   step_r, step_nxt;
  logic        [TIME_W-1:0]   time_r, time_nxt;
  logic                       first_r, first_nxt;
  logic        [REC_W-1:0]    rec_r, rec_nxt;

  logic                       active;
  logic                       prev_above;
  logic                       curr_above;
  logic        [STEP_W-1:0]   step_inc;
  logic        [TIME_W:0]     time_sum;
  logic        [TIME_W-1:0]   time_inc;
  logic signed [ENERGY_W-1:0] exit_e;

  assign active     = fire && cfg.threshold_enable && (rec_r < cfg.max_records);
  assign prev_above = item.prev_energy >= cfg.threshold;
  assign curr_above = item.curr_energy >= cfg.threshold;

  // Saturating step and time counters
  assign step_inc = (step_r == {STEP_W{1'b1}}) ? step_r : step_r + 1'b1;
  assign time_sum = {1'b0, time_r} + {{(TIME_W+1-WAIT_W){1'b0}}, item.wait_time};
  assign time_inc = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];

  assign exit_e = cfg.use_inherent_energy ? item.curr_inherent : item.curr_energy;

  // Advance the excursion state for one beat
  always_comb begin
    entry_nxt = entry_r;
    peak_nxt  = peak_r;
    step_nxt  = step_r;
    time_nxt  = time_r;
    first_nxt = first_r;
    rec_nxt   = rec_r;
    res_valid = 1'b0;
    if (active) begin
      if (!prev_above && curr_above) begin
        entry_nxt = cfg.use_inherent_energy ? item.prev_inherent : item.prev_energy;
        peak_nxt  = item.curr_energy;
        first_nxt = 1'b1;
      end else if (prev_above && curr_above) begin
        if (item.curr_energy > peak_r) begin
          peak_nxt = item.curr_energy;
        end
        step_nxt = step_inc;
        time_nxt = time_inc;
      end else if (prev_above && !curr_above) begin
        step_nxt = '0;
        time_nxt = '0;
        if (first_r) begin
          res_valid = 1'b1;
          if (rec_r != {REC_W{1'b1}}) begin
            rec_nxt = rec_r + 1'b1;
          end
        end
      end
    end
  end

  // Record fields include the exit step
  assign res.ridge_energy = peak_r;
  assign res.steps_above  = step_inc;
  assign res.time_above   = time_inc;
  assign res.same_basin   = (exit_e == entry_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      peak_r  <= '0;
      step_r  <= '0;
      time_r  <= '0;
      first_r <= 1'b0;
      rec_r   <= '0;
    end else begin
      entry_r <= entry_nxt;
      peak_r  <= peak_nxt;
      step_r  <= step_nxt;
      time_r  <= time_nxt;
      first_r <= first_nxt;
      rec_r   <= rec_nxt;
    end
  end

endmodule

FILE: rtl/core/tpt_out_reg.sv
module tpt_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  tpt_pkg::tpt_res_t res,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output tpt_pkg::tpt_res_t out_res
);
  import tpt_pkg::*;

  logic     valid_r, valid_nxt;
  tpt_res_t res_r;

  // Load a new beat when empty or when the held one is taken
  assign take      = !valid_r || out_ready;
  assign valid_nxt = take ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/core/threshold_excursion_peak_tracker.sv
// Data path: a beat that closes an excursion is held in the input register, and
// its record is then loaded into the output register; the state update is combinational.
// Throughput: one input beat per cycle; the input register and the state update
// both advance whenever the output register is empty or being read.
// Reset (rst_n low, synchronous): all excursion state clears, registers return
// to threshold 0, tracking enabled, raw energies, limit 65535.
module threshold_excursion_peak_tracker (
  input  logic  clk,
  input  logic  rst_n,
  tpt_in_if.sink    in_bus,
  tpt_out_if.source out_bus,
  tpt_cfg_if.sink   cfg_bus
);
  import tpt_pkg::*;

  tpt_cfg_t  cfg;
  tpt_item_t in_item;
  tpt_item_t s1_item;
  tpt_res_t  res;
  tpt_res_t  out_res;
  logic      s1_valid;
  logic      take;
  logic      res_valid;
  logic      in_ready;
  logic      out_valid;

  assign cfg_bus.ready = 1'b1;

  tpt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  assign in_item.prev_energy   = in_bus.prev_energy;
  assign in_item.prev_inherent = in_bus.prev_inherent;
  assign in_item.curr_energy   = in_bus.curr_energy;
  assign in_item.curr_inherent = in_bus.curr_inherent;
  assign in_item.wait_time     = in_bus.wait_time;
  assign in_bus.ready          = in_ready;

  tpt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tpt_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (s1_valid && take),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  tpt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

  assign out_bus.valid        = out_valid;
  assign out_bus.ridge_energy = out_res.ridge_energy;
  assign out_bus.steps_above  = out_res.steps_above;
  assign out_bus.time_above   = out_res.time_above;
  assign out_bus.same_basin   = out_res.same_basin;

endmodule

FILE: rtl/core/tpt_checker.sv
module tpt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tpt_pkg::TIME_W-1:0]   out_time_above,
  input logic [tpt_pkg::STEP_W-1:0]   out_steps_above,
  input logic [tpt_pkg::ENERGY_W-1:0] out_ridge_energy
);
  import tpt_pkg::*;

  // Hold a stalled record
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("record dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_ridge_energy) && $stable(out_steps_above)
                                && $stable(out_time_above))
    else $error("record payload changed while stalled");

  // A fresh record follows an accepted input beat through the input and output registers
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("record without a matching input beat");

  // An empty output register never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind threshold_excursion_peak_tracker tpt_checker u_tpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_bus.valid),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_time_above   (out_bus.time_above),
  .out_steps_above  (out_bus.steps_above),
  .out_ridge_energy (out_bus.ridge_energy)
);
